>>> src/bee_pkg.sv
`timescale 1ns / 1ps
package bee_pkg;
	localparam int MAX_POINTS = 16;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;
	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_END     = 2'd1;
	localparam logic [1:0] REG_TENSION = 2'd2;
	localparam logic [1:0] REG_COUNT   = 2'd3;

	// roots 2^(2^-(i+1)) in Q.16
	function automatic logic [16:0] root_q16(input logic [3:0] i);
		logic [16:0] r;
		begin
			case (i)
				4'd0: r = 17'd92682;
				4'd1: r = 17'd77936;
				4'd2: r = 17'd71468;
				4'd3: r = 17'd68438;
				4'd4: r = 17'd66971;
				4'd5: r = 17'd66250;
				4'd6: r = 17'd65892;
				4'd7: r = 17'd65714;
				4'd8: r = 17'd65625;
				4'd9: r = 17'd65580;
				4'd10: r = 17'd65558;
				4'd11: r = 17'd65547;
				4'd12: r = 17'd65542;
				4'd13: r = 17'd65539;
				4'd14: r = 17'd65537;
				default: r = 17'd65537;
			endcase
			return r;
		end
	endfunction
endpackage

>>> src/breakpoint_envelope_evaluator_top.sv
`timescale 1ns / 1ps
// Breakpoint envelope evaluator. A write item (opcode 0) stores one point in
// the point memory and gives no result. An evaluate item (opcode 1) gives
// one level on the level port, marked by valid for one cycle; the receiver
// must take it then. Evaluation runs as a sequencer around the point memory:
// it primes the read, compares the points one by one and leaves the scan;
// then restoring division (cut short with a zero fraction when the span is
// 6 or less); a shaping step; with tension active a setup step, normalizing
// shifts, squarings, a multiply, an exponent step, root multiplies and a
// fix-up step; and an interpolation step. busy is high for the whole
// evaluation, and the level appears with valid in the cycle that busy falls.
// The point memory has no reset; points must be written before they are used.
module breakpoint_envelope_evaluator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [3:0]         point_index,
	input  logic [15:0]        point_pos,
	input  logic signed [15:0] point_level,
	input  logic [16:0]        phase,
	output logic               valid,
	output logic signed [15:0] level,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int MAX_POINTS = bee_pkg::MAX_POINTS;
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DIV, ST_SHAPE, ST_NORM, ST_SQ, ST_MULK, ST_EXP,
		ST_FINAL, ST_INTERP, ST_OUT
	} state_t;

	// configuration
	logic signed [15:0] start_q, end_q, tension_q;
	logic [4:0]         count_q;
	logic               wr_cfg;
	assign pready = 1'b1;
	assign wr_cfg = psel & penable & pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q <= '0;
			tension_q <= '0;
			count_q <= '0;
		end else if (wr_cfg) begin
			case (paddr[3:2])
				bee_pkg::REG_START:   start_q <= pwdata[15:0];
				bee_pkg::REG_END:     end_q <= pwdata[15:0];
				bee_pkg::REG_TENSION: tension_q <= pwdata[15:0];
				bee_pkg::REG_COUNT:   count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			bee_pkg::REG_START:   prdata = {{16{start_q[15]}}, start_q};
			bee_pkg::REG_END:     prdata = {{16{end_q[15]}}, end_q};
			bee_pkg::REG_TENSION: prdata = {{16{tension_q[15]}}, tension_q};
			bee_pkg::REG_COUNT:   prdata = {27'd0, count_q};
			default:              prdata = '0;
		endcase
	end

	// point memory: position and level in one word
	logic [31:0]   mem [MAX_POINTS];
	logic [31:0]   rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_pt;
	logic [AW:0]   wr_idx;
	assign wr_idx = {1'b0, point_index[AW-1:0]};
	assign wr_pt  = start & ~busy & (opcode == bee_pkg::OP_WRITE)
		& ({1'b0, point_index} < 5'(MAX_POINTS)) & (5'(wr_idx) == {1'b0, point_index});
	always_ff @(posedge clk) begin
		if (wr_pt) mem[point_index[AW-1:0]] <= {point_pos, point_level};
		rd_q <= mem[rd_addr];
	end

	state_t             st_q;
	logic [CW-1:0]      cnt_q;
	logic [CW:0]        ridx_q;   // read issue index
	logic [CW:0]        sidx_q;   // compare index
	logic [16:0]        t_q;
	logic [16:0]        ppos_q, npos_q;
	logic signed [15:0] plvl_q, nlvl_q;
	logic               found_q;
	logic [33:0]        rem_q;
	logic [16:0]        quo_q, div_q;
	logic [4:0]         step_q;
	logic [16:0]        x_q;      // fraction / pow argument / result
	logic [17:0]        m_q;
	logic [4:0]         s_q;
	logic [15:0]        f_q;
	logic [17:0]        k_q;
	logic [37:0]        y_q;
	logic [16:0]        acc_q;
	logic [15:0]        g2_q;
	logic               neg_q;
	logic signed [47:0] prod_q;

	assign busy = (st_q != ST_IDLE);
	assign rd_addr = ridx_q[AW-1:0];

	logic [15:0]        mag;
	logic [4:0]         cnt_c;
	logic [35:0]        sq;
	logic [33:0]        am;
	logic [16:0]        rpos;
	logic signed [17:0] rspan;
	logic signed [17:0] dl;
	logic signed [31:0] rsum;
	always_comb begin
		mag   = tension_q[15] ? 16'(-tension_q) : tension_q;
		cnt_c = (count_q > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : count_q;
		sq    = 36'(m_q) * 36'(m_q);
		am    = 34'(acc_q) * 34'(bee_pkg::root_q16(4'(step_q))) + 34'd32768;
		rpos  = {1'b0, rd_q[31:16]};
		rspan = $signed({1'b0, npos_q}) - $signed({1'b0, ppos_q});
		dl    = 18'(nlvl_q) - 18'(plvl_q);
		rsum  = 32'(plvl_q) + 32'(prod_q >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start && opcode == bee_pkg::OP_EVAL) begin
						t_q <= (phase > 17'd65536) ? 17'd65536 : phase;
						cnt_q <= CW'(cnt_c);
						ridx_q <= '0;
						sidx_q <= '0;
						ppos_q <= '0;
						plvl_q <= start_q;
						npos_q <= 17'd65536;
						nlvl_q <= end_q;
						found_q <= 1'b0;
						st_q <= ST_SCAN;
					end
				end
				// read ahead one entry, compare the one that arrives
				ST_SCAN: begin
					if (ridx_q < (CW+1)'(MAX_POINTS - 1) || (ridx_q == '0 && sidx_q == '0))
						ridx_q <= ridx_q + 1'b1;
					if (ridx_q != '0 || sidx_q != '0) begin
						if (sidx_q >= (CW+1)'(cnt_q) || found_q) begin
							st_q <= ST_DIV;
							step_q <= '0;
							div_q <= 17'(rspan);
							rem_q <= '0;
							quo_q <= t_q - ppos_q;
						end else begin
							sidx_q <= sidx_q + 1'b1;
							if (t_q <= rpos) begin
								npos_q <= rpos;
								nlvl_q <= rd_q[15:0];
								found_q <= 1'b1;
							end else begin
								ppos_q <= rpos;
								plvl_q <= rd_q[15:0];
							end
						end
					end
				end
				// restoring division of (t-prev)<<16 by span, one bit per cycle
				ST_DIV: begin
					if (rspan <= 18'sd6) begin
						x_q <= '0;
						st_q <= ST_SHAPE;
					end else if (step_q == 5'd17) begin
						st_q <= ST_SHAPE;
						x_q <= (quo_q > 17'd65536) ? 17'd65536 : quo_q;
					end else begin
						// first step gives the integer bit, then zeros shift in
						if (step_q == 5'd0) begin
							if (34'(quo_q) >= 34'(div_q)) begin
								rem_q <= 34'(quo_q) - 34'(div_q);
								quo_q <= 17'd1;
							end else begin
								rem_q <= 34'(quo_q);
								quo_q <= '0;
							end
							step_q <= 5'd1;
						end else begin
							step_q <= step_q + 1'b1;
							if ({rem_q[32:0], 1'b0} >= 34'(div_q)) begin
								rem_q <= {rem_q[32:0], 1'b0} - 34'(div_q);
								quo_q <= {quo_q[15:0], 1'b1};
							end else begin
								rem_q <= {rem_q[32:0], 1'b0};
								quo_q <= {quo_q[15:0], 1'b0};
							end
						end
					end
				end
				ST_SHAPE: begin
					if (mag < 16'd17) st_q <= ST_INTERP;
					else begin
						k_q <= 18'd16384 + 18'(mag) * 18'd5;
						neg_q <= tension_q[15];
						if (tension_q[15]) x_q <= 17'd65536 - x_q;
						st_q <= ST_NORM;
						s_q <= '0;
					end
				end
				ST_NORM: begin
					if (x_q == '0) begin
						st_q <= ST_FINAL;
					end else if (x_q[16]) begin
						st_q <= ST_FINAL;
					end else begin
						m_q <= 18'(x_q);
						s_q <= '0;
						step_q <= '0;
						f_q <= '0;
						st_q <= ST_SQ;
					end
				end
				// normalize one bit per cycle, then sixteen squarings
				ST_SQ: begin
					if (!m_q[16]) begin
						m_q <= m_q << 1;
						s_q <= s_q + 1'b1;
					end else if (step_q == 5'd16) begin
						st_q <= ST_MULK;
					end else begin
						step_q <= step_q + 1'b1;
						if (sq[33]) begin
							m_q <= sq[34:17];
							f_q <= {f_q[14:0], 1'b1};
						end else begin
							m_q <= sq[33:16];
							f_q <= {f_q[14:0], 1'b0};
						end
					end
				end
				ST_MULK: begin
					y_q <= (38'(k_q) * 38'(({16'd0, s_q, 16'd0} >> 0) - 37'(f_q))) >> 14;
					acc_q <= 17'd65536;
					step_q <= '0;
					st_q <= ST_EXP;
				end
				ST_EXP: begin
					g2_q <= 16'(17'd65536 - {1'b0, y_q[15:0]});
					if (y_q[15:0] == 16'd0) begin
						x_q <= (y_q[37:16] > 22'd16) ? 17'd0 : (17'd65536 >> y_q[20:16]);
						st_q <= ST_FINAL;
					end else if (y_q[37:16] > 22'd15) begin
						x_q <= '0;
						st_q <= ST_FINAL;
					end else begin
						st_q <= ST_OUT;
					end
				end
				// one fraction bit per cycle, a root multiply for each set bit
				ST_OUT: begin
					if (step_q == 5'd16) begin
						x_q <= acc_q >> (y_q[20:16] + 5'd1);
						st_q <= ST_FINAL;
					end else begin
						if (g2_q[15 - step_q[3:0]]) acc_q <= am[32:16];
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINAL: begin
					if (neg_q) x_q <= 17'd65536 - x_q;
					st_q <= ST_INTERP;
				end
				ST_INTERP: begin
					prod_q <= 48'(dl) * $signed({31'd0, x_q}) + 48'sd32768;
					st_q <= ST_IDLE;
					valid <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		if (rsum > 32'sd32767) level = 16'sh7fff;
		else if (rsum < -32'sd32768) level = 16'sh8000;
		else level = rsum[15:0];
	end
endmodule

>>> src/bee_checker.sv
`timescale 1ns / 1ps
module bee_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic valid,
	input logic pready
);
	// evaluate start raises busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode |=> busy) else $error("eval not busy");
	// a write start leaves block idle
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !opcode |=> !busy) else $error("write went busy");
	// result ends the evaluation
	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy && $past(busy)) else $error("stray result");
	a_valid_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("double result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind breakpoint_envelope_evaluator_top bee_checker u_bee_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.opcode(opcode), .valid(valid), .pready(pready)
);

>>> test/tb_breakpoint_envelope_evaluator_top.sv
`timescale 1ns / 1ps
module tb_breakpoint_envelope_evaluator_top;
	localparam int NPTS = 16;
	localparam int SETTLE = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	// Track the point table and registers, predict each level
	class envelope_scoreboard;
		logic [15:0] pos_tab [NPTS];
		int lvl_tab [NPTS];
		int start_lvl, end_lvl, tens;
		int unsigned count;
		int expected_levels [$];
		int errors;
		int unsigned roots [16] = '{92682, 77936, 71468, 68438, 66971, 66250, 65892, 65714,
			65625, 65580, 65558, 65547, 65542, 65539, 65537, 65537};

		function new();
			for (int i = 0; i < NPTS; i++) begin
				pos_tab[i] = 0;
				lvl_tab[i] = 0;
			end
			start_lvl = 0;
			end_lvl = 0;
			tens = 0;
			count = 0;
			errors = 0;
		endfunction

		function longint unsigned power_q16(longint unsigned v, longint unsigned k);
			longint unsigned m, y, acc, f, s, n, g, g2;
			if (v == 0) return 0;
			if (v >= 65536) return 65536;
			m = v;
			s = 0;
			while (m < 65536) begin
				m = m << 1;
				s++;
			end
			f = 0;
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 16;
				f = f << 1;
				if (m >= 131072) begin
					m = m >> 1;
					f = f | 1;
				end
			end
			y = (k * ((s << 16) - f)) >> 14;
			n = (y >> 16) > 64 ? 64 : (y >> 16);
			g = y & 65535;
			if (g == 0) return n > 16 ? 0 : (65536 >> n);
			if (n + 1 > 16) return 0;
			g2 = 65536 - g;
			acc = 65536;
			for (int i = 0; i < 16; i++)
				if (g2[15-i])
					acc = (acc * roots[i] + 32768) >> 16;
			return acc >> (n + 1);
		endfunction

		function int predict_level(int unsigned ph);
			int unsigned t, cnt, mag;
			longint c, span, prev_pos, next_pos, prev_lvl, next_lvl, prod, res;
			t = ph > 65536 ? 65536 : ph;
			cnt = count > NPTS ? NPTS : count;
			prev_pos = 0;
			prev_lvl = start_lvl;
			next_pos = 65536;
			next_lvl = end_lvl;
			// scan for the first point at or above the phase
			for (int i = 0; i < cnt; i++) begin
				if (t <= pos_tab[i]) begin
					next_pos = pos_tab[i];
					next_lvl = lvl_tab[i];
					break;
				end
				prev_pos = pos_tab[i];
				prev_lvl = lvl_tab[i];
			end
			span = next_pos - prev_pos;
			if (span <= 6) c = 0;
			else c = ((longint'(t) - prev_pos) << 16) / span;
			if (c > 65536) c = 65536;
			// shape with the tension curve
			mag = tens < 0 ? -tens : tens;
			if (mag >= 17) begin
				if (tens > 0) c = power_q16(c, 16384 + 5 * mag);
				else c = 65536 - power_q16(65536 - c, 16384 + 5 * mag);
			end
			prod = (next_lvl - prev_lvl) * c + 32768;
			res = prev_lvl + (prod >>> 16);
			if (res > 32767) res = 32767;
			if (res < -32768) res = -32768;
			return int'(res);
		endfunction

		function void note_item(logic op, logic [3:0] idx, logic [15:0] pos,
				logic signed [15:0] lvl, logic [16:0] ph);
			if (op == bee_pkg::OP_WRITE) begin
				pos_tab[idx] = pos;
				lvl_tab[idx] = lvl;
			end else
				expected_levels.push_back(predict_level(ph));
		endfunction

		function void check_level(logic signed [15:0] got);
			int want;
			if (expected_levels.size() == 0) begin
				$display("%0t: unexpected level, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = expected_levels.pop_front();
			if (int'(got) != want) begin
				$display("%0t: level mismatch, expected %0d, actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic opcode = bee_pkg::OP_WRITE;
	logic [3:0] point_index = 0;
	logic [15:0] point_pos = 0;
	logic signed [15:0] point_level = 0;
	logic [16:0] phase = 0;
	logic valid;
	logic signed [15:0] level;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	envelope_scoreboard sb = new();
	int idle_pct = 0;
	int quiet_cycles = 0;

	breakpoint_envelope_evaluator_top dut (.*);

	always #5 clk = ~clk;

	// Check each level strobe
	always @(posedge clk)
		if (arst_n && valid)
			sb.check_level(level);

	// Drop the run if nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || valid || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_breakpoint_envelope_evaluator_top: done, errors");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] r, int value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (r)
			bee_pkg::REG_START: sb.start_lvl = int'(signed'(value[15:0]));
			bee_pkg::REG_END: sb.end_lvl = int'(signed'(value[15:0]));
			bee_pkg::REG_TENSION: sb.tens = int'(signed'(value[15:0]));
			default: sb.count = value[4:0];
		endcase
	endtask

	// Hold start until the item is taken; idle first at the sender's rate
	task automatic send_item(logic op, logic [3:0] idx, logic [15:0] pos,
			logic signed [15:0] lvl, logic [16:0] ph);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
		end
		start <= 1;
		opcode <= op;
		point_index <= idx;
		point_pos <= pos;
		point_level <= lvl;
		phase <= ph;
		do @(posedge clk); while (busy);
		sb.note_item(op, idx, pos, lvl, ph);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.expected_levels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic configure(int s, int e, int t, int c);
		reg_write(bee_pkg::REG_START, s);
		reg_write(bee_pkg::REG_END, e);
		reg_write(bee_pkg::REG_TENSION, t);
		reg_write(bee_pkg::REG_COUNT, c);
	endtask

	// Fill all slots with ascending positions, at times bunched close together
	task automatic load_sorted_points();
		int pos [NPTS];
		int bunch;
		bunch = $urandom_range(0, 3) == 0;
		for (int i = 0; i < NPTS; i++)
			pos[i] = bunch ? $urandom_range(0, 40) + i * $urandom_range(0, 4)
				: $urandom_range(0, 65535);
		pos.sort();
		for (int i = 0; i < NPTS; i++)
			send_item(bee_pkg::OP_WRITE, 4'(i), 16'(pos[i]), 16'($urandom), 17'd0);
	endtask

	function automatic logic [16:0] pick_phase();
		int r, p;
		r = $urandom_range(0, 9);
		if (r < 5) return 17'($urandom_range(0, 65536));
		if (r < 8) begin
			p = int'(sb.pos_tab[$urandom_range(0, NPTS - 1)]) + $urandom_range(0, 2) - 1;
			return 17'(p < 0 ? 0 : p);
		end
		if (r == 8) return 17'($urandom_range(65536, 131071));
		return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
	endfunction

	task automatic run_random(int items);
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(0, 99) < 75)
				send_item(bee_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
					pick_phase());
			else if ($urandom_range(0, 19) == 0)
				load_sorted_points();
			else
				send_item(bee_pkg::OP_WRITE, 4'($urandom), 16'($urandom), 16'($urandom),
					17'($urandom));
		end
	endtask

	initial begin
		int cfg [8][4] = '{
			'{-32768, 32767, 0, 16},
			'{32767, -32768, 16384, 16},
			'{100, -200, -16384, 8},
			'{-32768, 32767, 32767, 31},
			'{5, 7, -32768, 20},
			'{-5000, 9000, 16, 16},
			'{-1000, 1000, -17, 3},
			'{300, -300, 17, 0}};
		int pcts [4] = '{0, 48, 0, 19};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: defaults, then a full table with extreme values
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd0);
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd65536);
		send_item(bee_pkg::OP_EVAL, 4'd15, 16'hFFFF, -16'sd1, 17'h1FFFF);
		for (int i = 0; i < NPTS; i++)
			send_item(bee_pkg::OP_WRITE, 4'(i), 16'(i == NPTS - 1 ? 65535 : i * 4096),
				16'(i[0] ? 32767 : -32768), 17'd0);
		drain();
		configure(-32768, 32767, 0, 16);
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd0);
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd4096);
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd6000);
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd65535);
		send_item(bee_pkg::OP_EVAL, 4'd0, 16'd0, 16'sd0, 17'd65536);

		// Random phases, each with its own register setting
		for (int ph = 0; ph < 11; ph++) begin
			drain();
			idle_pct = pcts[ph % 4];
			if (ph < 8)
				configure(cfg[ph][0], cfg[ph][1], cfg[ph][2], cfg[ph][3]);
			else
				configure($urandom, $urandom, $urandom_range(0, 1) ?
					$urandom : $urandom_range(0, 32) - 16, $urandom_range(0, 31));
			load_sorted_points();
			run_random(54);
		end

		drain();
		if (sb.errors == 0)
			$display("tb_breakpoint_envelope_evaluator_top: done, clean");
		else
			$display("tb_breakpoint_envelope_evaluator_top: done, errors");
		$finish;
	end
endmodule
